[rtl/rbem_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rbem_pkg;

    localparam int MAX_WIDTH    = 2048;
    localparam int MAX_HEIGHT   = 4096;
    localparam int MAX_CHANNELS = 4;
    localparam int STORE_DEPTH  = MAX_WIDTH * MAX_CHANNELS;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);

    localparam int PIX_W   = 8;
    localparam int WIDTH_W = 12;
    localparam int HEIGHT_W = 13;
    localparam int CHAN_W  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam int COL_W  = 11;
    localparam int ROW_W  = 12;
    localparam int CPOS_W = 2;

    localparam int SQ_W   = 2 * PIX_W;
    localparam int SUM_W  = SQ_W + 1;
    localparam int RAD_W  = 18;
    localparam int ROOT_W = 9;
    localparam int REM_W  = 11;
    localparam int REMX_W = REM_W + 2;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);
    localparam logic [CHAN_W-1:0]   CHAN_RESET   = CHAN_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH    = 2'd0,
        CFG_HEIGHT   = 2'd1,
        CFG_CHANNELS = 2'd2
    } t_cfg_idx;

    // side data that rides along with each result through the pipeline
    typedef struct packed {
        logic zero;
        logic last;
    } t_tag;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } t_sq;

    // one radix-2 digit (one root bit from one bit pair) of a restoring integer square root
    function automatic t_sq sqrt_digit(t_sq a, logic [1:0] pair);
        logic [REMX_W-1:0] rem_x;
        logic [REMX_W-1:0] trial;
        t_sq               res;
        rem_x = {a.rem, pair};
        trial = {2'b00, a.root, 2'b01};
        if (rem_x >= trial) begin
            res.rem  = REM_W'(rem_x - trial);
            res.root = {a.root[ROOT_W-2:0], 1'b1};
        end else begin
            res.rem  = rem_x[REM_W-1:0];
            res.root = {a.root[ROOT_W-2:0], 1'b0};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[rtl/rbem_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface rbem_sample_if import rbem_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] sample;
    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface rbem_result_if import rbem_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] edge_value;
    logic             last_of_image;
    modport source (output valid, output edge_value, output last_of_image, input ready);
    modport sink   (input valid, input edge_value, input last_of_image, output ready);
endinterface

interface rbem_cfg_if import rbem_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/rbem_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module rbem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // read-first: a read at the written address returns the old word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

`default_nettype wire

[rtl/rbem_isqrt.sv]
`timescale 1ns / 1ps
`default_nettype none

module rbem_isqrt import rbem_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [SUM_W-1:0] i_sum,
    input  wire t_tag             i_tag,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic      [PIX_W-1:0] o_edge,
    output logic                  o_last
);

    localparam int NSTG  = 3;
    localparam int DPS   = (ROOT_W + NSTG - 1) / NSTG;

    logic [RAD_W-1:0] w_rad;
    logic             r_val  [NSTG];
    logic [RAD_W-1:0] r_rad  [NSTG];
    t_sq              r_sq   [NSTG];
    t_tag             r_tag  [NSTG];
    logic             w_load [NSTG+1];
    logic             r_out_valid;

    assign w_rad = RAD_W'(i_sum);

    // ready chain: a stage loads when empty or when the next one moves
    assign w_load[NSTG] = !r_out_valid || i_ready;
    for (genvar k = 0; k < NSTG; k++) begin : g_ld
        assign w_load[k] = !r_val[k] || w_load[k+1];
    end
    assign o_ready = w_load[0];

    for (genvar k = 0; k < NSTG; k++) begin : g_stg
        t_sq              w_in;
        logic [RAD_W-1:0] w_src;
        logic             w_vin;
        t_tag             w_tin;
        t_sq              w_step [DPS+1];
        t_sq              n_sq;

        if (k == 0) begin : g_first
            assign w_in  = '0;
            assign w_src = w_rad;
            assign w_vin = i_valid;
            assign w_tin = i_tag;
        end else begin : g_rest
            assign w_in  = r_sq[k-1];
            assign w_src = r_rad[k-1];
            assign w_vin = r_val[k-1];
            assign w_tin = r_tag[k-1];
        end

        assign w_step[0] = w_in;
        for (genvar j = 0; j < DPS; j++) begin : g_dig
            localparam int D = ROOT_W - 1 - k * DPS - j;
            assign w_step[j+1] = sqrt_digit(w_step[j], w_src[2*D+1 -: 2]);
        end
        assign n_sq = w_step[DPS];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_val[k] <= 1'b0;
            end else if (w_load[k]) begin
                r_val[k] <= w_vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_load[k]) begin
                r_sq[k]  <= n_sq;
                r_rad[k] <= w_src;
                r_tag[k] <= w_tin;
            end
        end
    end

    // rounding: floor root plus one when remainder exceeds the root
    logic             w_up;
    logic [ROOT_W:0]  w_rnd;
    logic [PIX_W-1:0] n_edge;
    t_sq              w_fin;

    assign w_fin = r_sq[NSTG-1];
    assign w_up  = w_fin.rem > REM_W'(w_fin.root);
    assign w_rnd = {1'b0, w_fin.root} + (ROOT_W+1)'(w_up);

    always_comb begin
        if (r_tag[NSTG-1].zero) begin
            n_edge = '0;
        end else if (w_rnd > (ROOT_W+1)'(255)) begin
            n_edge = '1;
        end else begin
            n_edge = w_rnd[PIX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load[NSTG]) begin
            r_out_valid <= r_val[NSTG-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load[NSTG]) begin
            o_edge <= n_edge;
            o_last <= r_tag[NSTG-1].last;
        end
    end

    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

[rtl/roberts_edge_magnitude_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel    dir   transfer moves                       when
// i_sample   in    one channel byte, raster order       valid && ready
// o_result   out   edge_value, last_of_image            valid && ready
// i_cfg      in    register index, write data           valid (ready held high)
//
// one byte per clock while o_result takes results; a result passes from the
// byte that completes it through line store read, squares, sum, three root
// stages and rounding. results lag the input by one image row; row 0 gives
// none. reset sets 640 x 480 x 1 and row/column/channel 0; the line store
// is not cleared, row 0 of each image fills it before any read that feeds a result.
// a stall at o_result backs up stage by stage; empty stages still load.
module roberts_edge_magnitude_unit import rbem_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    rbem_sample_if.sink   i_sample,
    rbem_result_if.source o_result,
    rbem_cfg_if.sink      i_cfg
);

    // configuration registers
    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;
    logic [CHAN_W-1:0]   r_chans;
    logic [WIDTH_W-1:0]  n_width;
    logic [HEIGHT_W-1:0] n_height;
    logic [CHAN_W-1:0]   n_chans;
    logic                w_cfg_hit;
    logic                w_cfg_xfer;

    // raster position
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_col;
    logic [CPOS_W-1:0] r_cpos;
    logic [ADDR_W-1:0] r_idx;

    logic w_acc;
    logic w_row_last, w_col_last, w_chan_last;

    assign i_cfg.ready = 1'b1;
    assign w_cfg_xfer  = i_cfg.valid;

    // clamp each written value into its legal range
    always_comb begin
        n_width   = r_width;
        n_height  = r_height;
        n_chans   = r_chans;
        w_cfg_hit = 1'b0;
        case (i_cfg.index)
            CFG_WIDTH: begin
                w_cfg_hit = 1'b1;
                if (i_cfg.data[WIDTH_W-1:0] == '0) begin
                    n_width = WIDTH_W'(1);
                end else if (i_cfg.data[WIDTH_W-1:0] > WIDTH_W'(MAX_WIDTH)) begin
                    n_width = WIDTH_W'(MAX_WIDTH);
                end else begin
                    n_width = i_cfg.data[WIDTH_W-1:0];
                end
            end
            CFG_HEIGHT: begin
                w_cfg_hit = 1'b1;
                if (i_cfg.data[HEIGHT_W-1:0] == '0) begin
                    n_height = HEIGHT_W'(1);
                end else if (i_cfg.data[HEIGHT_W-1:0] > HEIGHT_W'(MAX_HEIGHT)) begin
                    n_height = HEIGHT_W'(MAX_HEIGHT);
                end else begin
                    n_height = i_cfg.data[HEIGHT_W-1:0];
                end
            end
            CFG_CHANNELS: begin
                w_cfg_hit = 1'b1;
                if (i_cfg.data[CHAN_W-1:0] == '0) begin
                    n_chans = CHAN_W'(1);
                end else if (i_cfg.data[CHAN_W-1:0] > CHAN_W'(MAX_CHANNELS)) begin
                    n_chans = CHAN_W'(MAX_CHANNELS);
                end else begin
                    n_chans = i_cfg.data[CHAN_W-1:0];
                end
            end
            default: begin
                w_cfg_hit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
            r_chans  <= CHAN_RESET;
        end else if (w_cfg_xfer) begin
            r_width  <= n_width;
            r_height <= n_height;
            r_chans  <= n_chans;
        end
    end

    // position flags: counters never pass their limits, so equality does
    assign w_chan_last = ({1'b0, r_cpos} == CHAN_W'(r_chans - CHAN_W'(1)));
    assign w_col_last  = ({1'b0, r_col} == WIDTH_W'(r_width - WIDTH_W'(1)));
    assign w_row_last  = ({1'b0, r_row} == HEIGHT_W'(r_height - HEIGHT_W'(1)));

    // stage handshake chain
    logic w_load1, w_load2, w_load3;
    logic w_sq_ready;

    assign i_sample.ready = w_load1;
    assign w_acc          = i_sample.valid && w_load1;

    // raster counters; r_idx is column * channels + channel kept as a count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_cpos <= '0;
            r_idx  <= '0;
        end else if (w_cfg_xfer && w_cfg_hit) begin
            r_row  <= '0;
            r_col  <= '0;
            r_cpos <= '0;
            r_idx  <= '0;
        end else if (w_acc) begin
            if (!w_chan_last) begin
                r_cpos <= r_cpos + CPOS_W'(1);
                r_idx  <= r_idx + ADDR_W'(1);
            end else begin
                r_cpos <= '0;
                if (!w_col_last) begin
                    r_col <= r_col + COL_W'(1);
                    r_idx <= r_idx + ADDR_W'(1);
                end else begin
                    r_col <= '0;
                    r_idx <= '0;
                    if (w_row_last) begin
                        r_row <= '0;
                    end else begin
                        r_row <= r_row + ROW_W'(1);
                    end
                end
            end
        end
    end

    // line store: the pixel above and its right neighbor read together,
    // the current byte written over the one above in the same cycle
    logic [PIX_W-1:0]  w_above;
    logic [PIX_W-1:0]  w_diag;
    logic [ADDR_W-1:0] w_next_addr;

    assign w_next_addr = r_idx + ADDR_W'(r_chans);

    rbem_ram #(
        .WIDTH (PIX_W),
        .DEPTH (STORE_DEPTH)
    ) u_line (
        .i_clk     (i_clk),
        .i_we      (w_acc),
        .i_waddr   (r_idx),
        .i_wdata   (i_sample.sample),
        .i_re      (w_load1),
        .i_raddr_a (r_idx),
        .i_raddr_b (w_next_addr),
        .o_rdata_a (w_above),
        .o_rdata_b (w_diag)
    );

    // stage 1: current byte, border and end-of-image marks
    logic             r1_valid;
    logic [PIX_W-1:0] r1_cur;
    t_tag             r1_tag;
    t_tag             n1_tag;

    // the result row is r_row - 1; its top row and both edge columns are zero
    assign n1_tag.zero = (r_row < ROW_W'(2)) || (r_col == '0) || w_col_last;
    assign n1_tag.last = w_row_last && w_col_last && w_chan_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_load1) begin
            r1_valid <= w_acc && (r_row != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load1) begin
            r1_cur <= i_sample.sample;
            r1_tag <= n1_tag;
        end
    end

    // stage 2: squared differences
    logic            r2_valid;
    logic [SQ_W-1:0] r2_dx2, r2_dy2;
    t_tag            r2_tag;
    logic [PIX_W-1:0] w_adx, w_ady;

    assign w_adx = (w_above >= r1_cur) ? (w_above - r1_cur) : (r1_cur - w_above);
    assign w_ady = (w_above >= w_diag) ? (w_above - w_diag) : (w_diag - w_above);

    assign w_load1 = !r1_valid || w_load2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_load2) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load2) begin
            r2_dx2 <= w_adx * w_adx;
            r2_dy2 <= w_ady * w_ady;
            r2_tag <= r1_tag;
        end
    end

    // stage 3: sum of squares
    logic             r3_valid;
    logic [SUM_W-1:0] r3_sum;
    t_tag             r3_tag;

    assign w_load2 = !r2_valid || w_load3;
    assign w_load3 = !r3_valid || w_sq_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (w_load3) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load3) begin
            r3_sum <= {1'b0, r2_dx2} + {1'b0, r2_dy2};
            r3_tag <= r2_tag;
        end
    end

    // root, rounding and saturation; its last stage is the output register
    rbem_isqrt u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r3_valid),
        .o_ready (w_sq_ready),
        .i_sum   (r3_sum),
        .i_tag   (r3_tag),
        .o_valid (o_result.valid),
        .i_ready (o_result.ready),
        .o_edge  (o_result.edge_value),
        .o_last  (o_result.last_of_image)
    );

endmodule

`default_nettype wire
